@@ hdl/stq_pkg.sv @@
`default_nettype none
package stq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned IdBitsDefault = 16;

  localparam int unsigned TimeBits = 62;
  localparam int unsigned IvlBits = 32;
  localparam int unsigned HandleBits = 32;
  localparam int unsigned WantBits = 16;
  localparam int unsigned ProdBits = 42;

  typedef enum logic [1:0] {
    MODE_SCHED   = 2'd0,
    MODE_UNSCHED = 2'd1,
    MODE_TICK    = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_INS  = 2'd1,
    CMD_REM  = 2'd2,
    CMD_POP  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [TimeBits-1:0]   due;
    logic [IvlBits-1:0]    ivl;
    logic [HandleBits-1:0] handle;
  } entry_t;

  // Broadcast command seen by every cell of the chain.
  typedef struct packed {
    cell_op_t            op;
    logic [TimeBits-1:0] key;
    logic [WantBits-1:0] want;
  } cell_cmd_t;

endpackage
`default_nettype wire

@@ hdl/stq_ifs.sv @@
`default_nettype none
interface stq_in_if;
  import stq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [TimeBits-1:0]   due_time;
  logic [IvlBits-1:0]    interval_us;
  logic [HandleBits-1:0] task_handle;
  logic [WantBits-1:0]   task_ident;
  logic [TimeBits-1:0]   now_time;
  modport source (output valid, mode, due_time, interval_us, task_handle, task_ident,
                  now_time, input ready);
  modport sink (input valid, mode, due_time, interval_us, task_handle, task_ident,
                now_time, output ready);
endinterface

interface stq_out_if;
  import stq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [WantBits-1:0]   result_ident;
  logic                  fire;
  logic [HandleBits-1:0] fired_handle;
  modport source (output valid, ok, result_ident, fire, fired_handle, input ready);
  modport sink (input valid, ok, result_ident, fire, fired_handle, output ready);
endinterface
`default_nettype wire

@@ hdl/stq_cell.sv @@
`default_nettype none
module stq_cell import stq_pkg::*; #(
  parameter int unsigned ID_BITS = IdBitsDefault
) (
  input  wire logic               clk,
  input  wire cell_cmd_t          cmd,
  input  wire logic               occupied,
  input  wire entry_t             new_ent,
  input  wire logic [ID_BITS-1:0] new_id,
  input  wire entry_t             left_ent,
  input  wire logic [ID_BITS-1:0] left_id,
  input  wire entry_t             right_ent,
  input  wire logic [ID_BITS-1:0] right_id,
  input  wire logic               gt_left,
  input  wire logic               hit_left,
  output entry_t                  ent_o,
  output logic [ID_BITS-1:0]      id_o,
  output logic                    gt_o,
  output logic                    hit_o
);

  localparam int unsigned CmpBits = (ID_BITS > WantBits) ? ID_BITS : WantBits;

  entry_t             ent_r;
  logic [ID_BITS-1:0] id_r;
  logic               own_hit;

  // A free cell counts as later than any key, so an insert that no occupied due time exceeds lands at the tail.
  assign gt_o = !occupied || (ent_r.due > cmd.key);
  assign own_hit = occupied &&
                   (CmpBits'(id_r) == CmpBits'(cmd.want));
  assign hit_o = hit_left || own_hit;
  assign ent_o = ent_r;
  assign id_o = id_r;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_INS: begin
        if (gt_o) begin
          ent_r <= gt_left ? left_ent : new_ent;
          id_r  <= gt_left ? left_id : new_id;
        end
      end
      CMD_REM: begin
        if (hit_o) begin
          ent_r <= right_ent;
          id_r  <= right_id;
        end
      end
      CMD_POP: begin
        ent_r <= right_ent;
        id_r  <= right_id;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/sorted_timer_task_queue_top.sv @@
`default_nettype none
// Sorted timer task queue.
// Items arrive on in_ch (valid/ready) with a mode: schedule, unschedule,
// time tick or running-task done. Every accepted item yields exactly one
// result item on out_ch: ok flag, assigned or fired id, fire flag and the
// fired handle.
// Tasks live in a chain of QUEUE_DEPTH cells ordered by due time. An insert,
// removal or pop is one broadcast command; each cell checks the key or the
// wanted id and either holds its own entry or takes the new entry, its left
// or its right neighbor's entry in the same cycle.
// An item is captured, executed the next cycle, and its result is held in
// the output register. A done that re-arms a periodic task passes through
// an extra state that registers interval times 1000 before the saturating
// add. The next item is taken in the cycle its predecessor's result is
// taken. While the receiver stalls, the result holds and no new item is
// accepted.
// Synchronous active-low reset empties the queue, clears the id counter and
// the running task; no clearing pass is needed, so the block is ready
// immediately after reset.
module sorted_timer_task_queue_top import stq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned ID_BITS = IdBitsDefault
) (
  input wire logic   clk,
  input wire logic   rst_n,
  stq_in_if.sink     in_ch,
  stq_out_if.source  out_ch
);

  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CmpBits = (ID_BITS > WantBits) ? ID_BITS : WantBits;
  localparam logic [CntBits-1:0] Full = CntBits'(QUEUE_DEPTH);
  localparam logic [TimeBits:0] TimeMax = {1'b0, {TimeBits{1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_ARM  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Captured item.
  mode_t                 mode_r;
  logic [TimeBits-1:0]   due_r;
  logic [IvlBits-1:0]    ivl_r;
  logic [HandleBits-1:0] hnd_r;
  logic [WantBits-1:0]   want_r;
  logic [TimeBits-1:0]   now_r;

  logic [CntBits-1:0]    cnt_r, cnt_nxt;
  logic [ID_BITS-1:0]    last_id_r, last_id_nxt;
  logic [ID_BITS-1:0]    run_id_r, run_id_nxt;
  logic                  busy_r, busy_nxt;
  logic [IvlBits-1:0]    run_ivl_r, run_ivl_nxt;
  logic [HandleBits-1:0] run_hnd_r, run_hnd_nxt;
  logic [ProdBits-1:0]   prod_r, prod_nxt;

  logic                  ok_r, ok_nxt;
  logic [WantBits-1:0]   rid_r, rid_nxt;
  logic                  fire_r, fire_nxt;
  logic [HandleBits-1:0] fh_r, fh_nxt;

  cell_cmd_t          cmd;
  entry_t             new_ent;
  logic [ID_BITS-1:0] new_id;

  entry_t             ent   [QUEUE_DEPTH];
  logic [ID_BITS-1:0] ids   [QUEUE_DEPTH];
  logic               gt    [QUEUE_DEPTH];
  logic               hit   [QUEUE_DEPTH];

  logic               accept;
  logic [ID_BITS-1:0] next_id;
  logic [TimeBits:0]  arm_sum;
  logic [TimeBits-1:0] arm_time;

  assign in_ch.ready = (state_r == S_IDLE) || ((state_r == S_OUT) && out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.ok           = ok_r;
  assign out_ch.result_ident = rid_r;
  assign out_ch.fire         = fire_r;
  assign out_ch.fired_handle = fh_r;

  // Ids count modulo 2^ID_BITS and skip zero.
  assign next_id = ((last_id_r + 1'b1) == '0) ? ID_BITS'(1) : (last_id_r + 1'b1);

  assign arm_sum  = {1'b0, now_r} + (TimeBits + 1)'(prod_r);
  assign arm_time = (arm_sum > TimeMax) ? TimeMax[TimeBits-1:0] : arm_sum[TimeBits-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t             l_ent, r_ent;
      logic [ID_BITS-1:0] l_id, r_id;
      logic               l_gt, l_hit, occ;
      if (gi == 0) begin : g_first
        assign l_ent = new_ent;
        assign l_id  = new_id;
        assign l_gt  = 1'b0;
        assign l_hit = 1'b0;
      end else begin : g_mid
        assign l_ent = ent[gi-1];
        assign l_id  = ids[gi-1];
        assign l_gt  = gt[gi-1];
        assign l_hit = hit[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign r_ent = ent[gi];
        assign r_id  = ids[gi];
      end else begin : g_inner
        assign r_ent = ent[gi+1];
        assign r_id  = ids[gi+1];
      end
      assign occ = (CntBits'(gi) < cnt_r);
      stq_cell #(.ID_BITS(ID_BITS)) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .occupied (occ),
        .new_ent  (new_ent),
        .new_id   (new_id),
        .left_ent (l_ent),
        .left_id  (l_id),
        .right_ent(r_ent),
        .right_id (r_id),
        .gt_left  (l_gt),
        .hit_left (l_hit),
        .ent_o    (ent[gi]),
        .id_o     (ids[gi]),
        .gt_o     (gt[gi]),
        .hit_o    (hit[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    last_id_nxt = last_id_r;
    run_id_nxt  = run_id_r;
    busy_nxt    = busy_r;
    run_ivl_nxt = run_ivl_r;
    run_hnd_nxt = run_hnd_r;
    prod_nxt    = prod_r;
    ok_nxt      = ok_r;
    rid_nxt     = rid_r;
    fire_nxt    = fire_r;
    fh_nxt      = fh_r;
    cmd.op      = CMD_NONE;
    cmd.key     = due_r;
    cmd.want    = want_r;
    new_ent.due    = due_r;
    new_ent.ivl    = ivl_r;
    new_ent.handle = hnd_r;
    new_id         = next_id;

    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        ok_nxt    = 1'b0;
        rid_nxt   = '0;
        fire_nxt  = 1'b0;
        fh_nxt    = '0;
        state_nxt = S_OUT;
        unique case (mode_r)
          MODE_SCHED: begin
            if (cnt_r != Full) begin
              cmd.op      = CMD_INS;
              cnt_nxt     = cnt_r + 1'b1;
              last_id_nxt = next_id;
              ok_nxt      = 1'b1;
              rid_nxt     = WantBits'(CmpBits'(next_id));
            end
          end
          MODE_UNSCHED: begin
            if (want_r != '0) begin
              if (CmpBits'(run_id_r) == CmpBits'(want_r)) begin
                run_id_nxt = '0;
                ok_nxt     = 1'b1;
              end else if (hit[QUEUE_DEPTH-1]) begin
                cmd.op  = CMD_REM;
                cnt_nxt = cnt_r - 1'b1;
                ok_nxt  = 1'b1;
              end
            end
          end
          MODE_TICK: begin
            if (!busy_r && (cnt_r != '0) && (ent[0].due <= now_r)) begin
              cmd.op      = CMD_POP;
              cnt_nxt     = cnt_r - 1'b1;
              busy_nxt    = 1'b1;
              run_id_nxt  = ids[0];
              run_ivl_nxt = ent[0].ivl;
              run_hnd_nxt = ent[0].handle;
              fire_nxt    = 1'b1;
              rid_nxt     = WantBits'(CmpBits'(ids[0]));
              fh_nxt      = ent[0].handle;
            end
          end
          MODE_DONE: begin
            if (busy_r) begin
              if ((run_ivl_r != '0) && (run_id_r != '0)) begin
                prod_nxt  = ProdBits'(run_ivl_r) * ProdBits'(1000);
                state_nxt = S_ARM;
              end else begin
                busy_nxt   = 1'b0;
                run_id_nxt = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_ARM: begin
        cmd.key        = arm_time;
        new_ent.due    = arm_time;
        new_ent.ivl    = run_ivl_r;
        new_ent.handle = run_hnd_r;
        new_id         = run_id_r;
        if (cnt_r != Full) begin
          cmd.op  = CMD_INS;
          cnt_nxt = cnt_r + 1'b1;
        end
        busy_nxt   = 1'b0;
        run_id_nxt = '0;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      last_id_r <= '0;
      run_id_r  <= '0;
      busy_r    <= 1'b0;
      run_ivl_r <= '0;
      run_hnd_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      last_id_r <= last_id_nxt;
      run_id_r  <= run_id_nxt;
      busy_r    <= busy_nxt;
      run_ivl_r <= run_ivl_nxt;
      run_hnd_r <= run_hnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    ok_r   <= ok_nxt;
    rid_r  <= rid_nxt;
    fire_r <= fire_nxt;
    fh_r   <= fh_nxt;
    if (accept) begin
      mode_r <= mode_t'(in_ch.mode);
      due_r  <= in_ch.due_time;
      ivl_r  <= in_ch.interval_us;
      hnd_r  <= in_ch.task_handle;
      want_r <= in_ch.task_ident;
      now_r  <= in_ch.now_time;
    end
  end

endmodule
`default_nettype wire

@@ sim/sorted_timer_task_queue_top_tb.sv @@
module sorted_timer_task_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stq_pkg::*;

  localparam int unsigned Depth = 16;
  localparam logic [61:0] TimeMax = {62{1'b1}};
  localparam int unsigned IdleLimit = 2000;

  // A result item as the block reports it.
  typedef struct packed {
    logic        ok;
    logic [15:0] ident;
    logic        fire;
    logic [31:0] handle;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  stq_in_if in_ch ();
  stq_out_if out_ch ();

  sorted_timer_task_queue_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the timer queue, kept sorted by due time.
  logic [61:0] q_due[Depth];
  logic [31:0] q_ivl[Depth];
  logic [15:0] q_id[Depth];
  logic [31:0] q_hnd[Depth];
  int unsigned q_len;
  logic [15:0] id_counter;
  logic [15:0] run_id;
  logic        run_busy;
  logic [31:0] run_ivl;
  logic [31:0] run_hnd;

  outcome_t pending[$];
  int unsigned errors;
  int unsigned fires_seen;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned mode_count[4];
  logic [61:0] clock_ns;

  function automatic bit shadow_insert(logic [61:0] due, logic [31:0] ivl,
                                       logic [15:0] id, logic [31:0] hnd);
    int unsigned pos;
    pos = 0;
    if (q_len >= Depth) return 1'b0;
    while (pos < q_len && q_due[pos] <= due) pos++;
    for (int unsigned i = q_len; i > pos; i--) begin
      q_due[i] = q_due[i-1];
      q_ivl[i] = q_ivl[i-1];
      q_id[i] = q_id[i-1];
      q_hnd[i] = q_hnd[i-1];
    end
    q_due[pos] = due;
    q_ivl[pos] = ivl;
    q_id[pos] = id;
    q_hnd[pos] = hnd;
    q_len++;
    return 1'b1;
  endfunction

  function automatic void shadow_remove(int unsigned pos);
    for (int unsigned i = pos; i + 1 < q_len; i++) begin
      q_due[i] = q_due[i+1];
      q_ivl[i] = q_ivl[i+1];
      q_id[i] = q_id[i+1];
      q_hnd[i] = q_hnd[i+1];
    end
    q_len--;
  endfunction

  // Applies one item to the shadow queue and returns the result it causes.
  function automatic outcome_t timer_predict(mode_t mode, logic [61:0] due,
      logic [31:0] ivl, logic [31:0] hnd, logic [15:0] want, logic [61:0] now);
    outcome_t r;
    logic [15:0] nid;
    logic [63:0] sum;
    bit found;
    bit dummy;
    r = '0;
    found = 1'b0;
    case (mode)
      MODE_SCHED: begin
        if (q_len < Depth) begin
          nid = id_counter + 16'd1;
          if (nid == 16'd0) nid = 16'd1;
          id_counter = nid;
          dummy = shadow_insert(due, ivl, nid, hnd);
          r.ok = 1'b1;
          r.ident = nid;
        end
      end
      MODE_UNSCHED: begin
        if (want != 16'd0) begin
          if (run_id == want) begin
            run_id = 16'd0;
            r.ok = 1'b1;
          end else begin
            for (int unsigned i = 0; i < q_len && !found; i++) begin
              if (q_id[i] == want) begin
                shadow_remove(i);
                found = 1'b1;
              end
            end
            r.ok = found;
          end
        end
      end
      MODE_TICK: begin
        if (!run_busy && q_len > 0 && q_due[0] <= now) begin
          run_busy = 1'b1;
          run_id = q_id[0];
          run_ivl = q_ivl[0];
          run_hnd = q_hnd[0];
          shadow_remove(0);
          r.fire = 1'b1;
          r.ident = run_id;
          r.handle = run_hnd;
        end
      end
      default: begin
        if (run_busy) begin
          if (run_ivl != 0 && run_id != 16'd0) begin
            sum = 64'(now) + 64'(run_ivl) * 64'd1000;
            if (sum > 64'(TimeMax)) sum = 64'(TimeMax);
            dummy = shadow_insert(sum[61:0], run_ivl, run_id, run_hnd);
          end
          run_busy = 1'b0;
          run_id = 16'd0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Sends one item, keeping valid high across back-to-back items.
  task automatic send_item(mode_t mode, logic [61:0] due, logic [31:0] ivl,
                           logic [31:0] hnd, logic [15:0] want, logic [61:0] now);
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.due_time <= due;
    in_ch.interval_us <= ivl;
    in_ch.task_handle <= hnd;
    in_ch.task_ident <= want;
    in_ch.now_time <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending.push_back(timer_predict(mode, due, ivl, hnd, want, now));
    mode_count[mode]++;
  endtask

  task automatic idle_sender(int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [61:0] rand_time();
    return 62'({$urandom(), $urandom()});
  endfunction

  // Receiver stall pattern: alternating free-running and stalling stretches.
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (stall_phase[8]) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    outcome_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result without expectation", 0, 0);
      end else begin
        exp_r = pending[0];
        pending.delete(0);
        if (out_ch.ok !== exp_r.ok) report_mismatch("ok", out_ch.ok, exp_r.ok);
        if (out_ch.result_ident !== exp_r.ident)
          report_mismatch("result_ident", out_ch.result_ident, exp_r.ident);
        if (out_ch.fire !== exp_r.fire) report_mismatch("fire", out_ch.fire, exp_r.fire);
        if (out_ch.fired_handle !== exp_r.handle)
          report_mismatch("fired_handle", out_ch.fired_handle, exp_r.handle);
        if (exp_r.fire) fires_seen++;
      end
    end
  end

  // Watchdog: ends the run if no handshake happens for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d results outstanding", pending.size());
      $display("FAIL");
      $finish;
    end
  end

  // Directed: extremes of the fields and each special case in turn.
  task automatic test_directed();
    // Tick and done on an empty block do nothing.
    send_item(MODE_TICK, 0, 0, 0, 0, TimeMax);
    send_item(MODE_DONE, 0, 0, 0, 0, TimeMax);
    // Unschedule of id zero never matches.
    send_item(MODE_UNSCHED, 0, 0, 0, 16'd0, 0);
    // Equal due times keep arrival order.
    send_item(MODE_SCHED, 62'd100, 32'd0, 32'hFFFF_FFFF, 0, 0);
    send_item(MODE_SCHED, 62'd100, 32'd0, 32'h0000_0001, 16'hFFFF, TimeMax);
    send_item(MODE_SCHED, TimeMax, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 0, 0);
    // Tick before the front is due.
    send_item(MODE_TICK, 0, 0, 0, 0, 62'd99);
    send_item(MODE_TICK, 0, 0, 0, 0, 62'd100);
    // Tick while a task runs does nothing.
    send_item(MODE_TICK, 0, 0, 0, 0, 62'd100);
    send_item(MODE_DONE, 0, 0, 0, 0, 62'd200);
    send_item(MODE_TICK, 0, 0, 0, 0, TimeMax);
    send_item(MODE_TICK, 0, 0, 0, 0, TimeMax);
    send_item(MODE_DONE, 0, 0, 0, 0, TimeMax);
    // Periodic task with saturating re-arm.
    send_item(MODE_TICK, 0, 0, 0, 0, TimeMax);
    send_item(MODE_DONE, 0, 0, 0, 0, TimeMax);
    send_item(MODE_SCHED, 62'd0, 32'd5, 32'h1234, 0, 0);
    send_item(MODE_TICK, 0, 0, 0, 0, 62'd0);
    // Cancelling the running task's re-arm.
    send_item(MODE_UNSCHED, 0, 0, 0, 16'd4, 0);
    send_item(MODE_DONE, 0, 0, 0, 0, 62'd10);
    send_item(MODE_UNSCHED, 0, 0, 0, 16'd3, 0);
    send_item(MODE_UNSCHED, 0, 0, 0, 16'd3, 0);
    drain_results();
  endtask

  // Fills the queue past full, then empties it.
  task automatic test_full_queue();
    // A periodic task is started first so that its re-arm meets a full queue.
    send_item(MODE_SCHED, 62'd0, 32'd1, 32'hC0DE_0001, 0, 0);
    send_item(MODE_TICK, 0, 0, 0, 0, 62'd0);
    for (int i = 0; i < Depth + 2; i++)
      send_item(MODE_SCHED, 62'($urandom_range(0, 50)), 32'($urandom_range(0, 2)),
                $urandom(), 0, 0);
    send_item(MODE_DONE, 0, 0, 0, 0, 62'd1000);
    for (int i = 0; i < Depth + 2; i++) begin
      send_item(MODE_TICK, 0, 0, 0, 0, 62'd1000);
      send_item(MODE_DONE, 0, 0, 0, 0, 62'd1000);
    end
    // Re-armed periodic tasks are removed by id scan.
    for (int i = 0; i < 64; i++) send_item(MODE_UNSCHED, 0, 0, 0, 16'(i), 0);
    drain_results();
  endtask

  // Random traffic around a slowly advancing clock, in bursts with gaps.
  task automatic test_random(int unsigned count);
    int unsigned sel;
    int unsigned burst;
    logic [15:0] want;
    burst = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 12));
      end
      burst--;
      clock_ns = clock_ns + 62'($urandom_range(0, 3000));
      sel = $urandom_range(0, 99);
      want = (id_counter > 20) ? id_counter - 16'($urandom_range(0, 20))
                               : 16'($urandom_range(0, 20));
      if (sel < 1) begin
        send_item(mode_t'($urandom_range(0, 3)), rand_time(), $urandom(), $urandom(),
                  16'($urandom()), rand_time());
      end else if (sel < 35) begin
        send_item(MODE_SCHED, clock_ns + 62'($urandom_range(0, 8000)),
                  ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 5)) : 32'd0,
                  $urandom(), 16'($urandom()), rand_time());
      end else if (sel < 45) begin
        send_item(MODE_UNSCHED, rand_time(), $urandom(), $urandom(), want, rand_time());
      end else if (sel < 75) begin
        send_item(MODE_TICK, rand_time(), $urandom(), $urandom(), 16'($urandom()),
                  clock_ns);
      end else begin
        send_item(MODE_DONE, rand_time(), $urandom(), $urandom(), 16'($urandom()),
                  clock_ns);
      end
    end
    drain_results();
  endtask

  // Schedules a task and removes it again at once, over and over.
  task automatic test_churn();
    for (int i = 0; i < 55; i++) begin
      send_item(MODE_SCHED, rand_time(), 32'd0, $urandom(), 0, 0);
      send_item(MODE_UNSCHED, 0, 0, 0, id_counter, 0);
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_SCHED;
    in_ch.due_time <= '0;
    in_ch.interval_us <= '0;
    in_ch.task_handle <= '0;
    in_ch.task_ident <= '0;
    in_ch.now_time <= '0;
    q_len = 0;
    id_counter = 0;
    run_id = 0;
    run_busy = 0;
    run_ivl = 0;
    run_hnd = 0;
    errors = 0;
    fires_seen = 0;
    results_seen = 0;
    clock_ns = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_queue();
    test_random(600);
    // Pause until every expected result has arrived, then continue.
    test_random(600);
    test_churn();
    repeat (10) @(posedge clk);
    if (pending.size() != 0) report_mismatch("results left over", pending.size(), 0);

    $display("covered %0d schedules, %0d unschedules, %0d ticks, %0d dones",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("%0d results checked, %0d fires, %0d mismatches",
             results_seen, fires_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
